[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file rvx_checker.sv.
// Depends on nothing; expects clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define CHK_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[hw/rtl/rvx_pkg.sv]
// Shared constants, codes and types of the RV32IM executor.
// Depends on nothing.
package rvx_pkg;

    localparam int MEM_WORDS = 16384;
    localparam int CSR_COUNT = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);
    localparam int CSR_AW    = $clog2(CSR_COUNT);
    localparam int REG_AW    = 5;
    localparam int CLR_N     = (MEM_WORDS > CSR_COUNT) ? MEM_WORDS : CSR_COUNT;
    localparam int CLR_AW    = $clog2(CLR_N);
    localparam logic [31:0] MEM_BYTES = 32'(MEM_WORDS * 4);

    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_FENCE  = 7'h0F;
    localparam logic [6:0] OPC_IMM    = 7'h13;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_REG    = 7'h33;
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_JAL    = 7'h6F;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_MULDIV = 7'h01;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_STEP  = 2'd2;

    localparam logic [1:0] CFG_MEM_BASE = 2'd0;
    localparam logic [1:0] CFG_ENTRY    = 2'd1;

    localparam logic [2:0] FLT_NONE    = 3'd0;
    localparam logic [2:0] FLT_ILLEGAL = 3'd1;
    localparam logic [2:0] FLT_TARGET  = 3'd2;
    localparam logic [2:0] FLT_RANGE   = 3'd3;
    localparam logic [2:0] FLT_DMIS    = 3'd4;
    localparam logic [2:0] FLT_BREAK   = 3'd5;
    localparam logic [2:0] FLT_FETCH   = 3'd6;

    typedef struct packed {
        logic       start;
        logic [2:0] funct3;
    } md_req_t;

endpackage

[hw/rtl/rv32im_instruction_executor.sv]
// RV32IM core with Zicsr: sequencer, decode and execute, built round three RAMs.
// Depends on rvx_pkg, rvx_ram and rvx_muldiv.
//
// After reset the block sweeps memory, CSR file and registers to zero, one
// entry a cycle, its index running to max(MEM_WORDS, CSR_COUNT) - 1; no word is
// taken on the slave side until then, configuration writes are taken at any time.
// Every input word yields one result word. A running step goes through fetch
// from the memory RAM, decode, two reads of the single-read-port register RAM,
// execute and write-back; loads and stores add a memory state, and multiplies
// and divides wait on rvx_muldiv, whose divider yields one bit a cycle. A result
// waiting on the master side does not stop the next word from being taken.
module rv32im_instruction_executor (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // word_index[13:0], word_data[45:14], zero pad
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // pc_after[31:0], running[32], exit_code[63:33],
                                    // fault[66:64], dest_reg[71:67], dest_value[103:72]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DEC, S_RA, S_RB, S_EX, S_MD, S_LD, S_ST, S_WB
    } state_t;

    typedef enum logic [1:0] {EXK_DONE, EXK_MD, EXK_LD, EXK_ST} exk_t;

    localparam int MAW = rvx_pkg::MEM_AW;

    state_t                    state_reg;
    logic [rvx_pkg::CLR_AW-1:0] clr_reg;
    logic [31:0]               pc_reg;
    logic                      run_reg;
    logic [30:0]               exit_reg;
    logic [31:0]               base_reg;
    logic [31:0]               entry_reg;
    logic [31:0]               insn_reg;
    logic [31:0]               a_reg;
    logic [31:0]               b_reg;
    logic [31:0]               csr_reg;
    logic [1:0]                ls_off_reg;
    logic [MAW-1:0]            ls_word_reg;
    logic [31:0]               res_pc_reg;
    logic                      res_run_reg;
    logic [30:0]               res_exit_reg;
    logic [2:0]                res_fault_reg;
    logic [4:0]                res_rd_reg;
    logic [31:0]               res_val_reg;
    logic                      res_csr_we_reg;
    logic [31:0]               res_csr_val_reg;
    logic                      mv_reg;
    logic [103:0]              mdata_reg;

    logic        accept;
    logic        out_free;
    logic        wb_go;
    logic [1:0]  kind;
    logic [13:0] widx;
    logic [31:0] wdata;
    logic [31:0] fetch_off;
    logic        fetch_flt;
    logic        clr_mem;
    logic        clr_csr;

    logic          mem_we;
    logic [MAW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [MAW-1:0] mem_raddr;
    logic [31:0]   mem_rdata;
    logic          rf_we;
    logic [4:0]    rf_waddr;
    logic [31:0]   rf_wdata;
    logic [4:0]    rf_raddr;
    logic [31:0]   rf_rdata;
    logic          csr_we;
    logic [rvx_pkg::CSR_AW-1:0] csr_waddr;
    logic [31:0]   csr_wdata;
    logic [31:0]   csr_rdata;

    logic [6:0]  op;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [4:0]  rs1;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] pc4;
    logic [31:0] tgt;
    logic [31:0] csr_src;
    logic [2:0]  ex_fault;
    logic        ex_wr;
    logic [31:0] ex_r;
    logic [31:0] ex_npc;
    exk_t        ex_kind;
    logic        ex_csr_we;
    logic [31:0] ex_csr_val;
    logic        ex_exit;
    logic        ex_take;
    logic [31:0] ex_addr;
    logic [31:0] ex_off;

    logic [4:0]  ls_sh;
    logic [31:0] ld_sw;
    logic [31:0] ld_val;
    logic [31:0] st_mask;
    logic [31:0] st_word;

    rvx_pkg::md_req_t md_req;
    logic             md_done;
    logic [31:0]      md_res;

    function automatic logic [2:0] acc_fault(input logic [31:0] addr,
                                             input logic [31:0] base,
                                             input logic [2:0]  nbytes);
        logic [31:0] off;
        begin
            off = addr - base;
            if ((nbytes == 3'd2 && addr[0]) || (nbytes == 3'd4 && addr[1:0] != 2'b00))
            begin
                return rvx_pkg::FLT_DMIS;
            end
            else if (off > rvx_pkg::MEM_BYTES - {29'd0, nbytes})
            begin
                return rvx_pkg::FLT_RANGE;
            end
            else
            begin
                return rvx_pkg::FLT_NONE;
            end
        end
    endfunction

    assign kind      = s_tuser;
    assign widx      = s_tdata[13:0];
    assign wdata     = s_tdata[45:14];
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !mv_reg || m_tready;
    assign wb_go     = (state_reg == S_WB) && out_free;
    assign m_tvalid  = mv_reg;
    assign m_tdata   = mdata_reg;

    assign fetch_off = pc_reg - base_reg;
    assign fetch_flt = (pc_reg[1:0] != 2'b00) ||
                       (fetch_off > rvx_pkg::MEM_BYTES - 32'd4);
    assign clr_mem   = {1'b0, clr_reg} < (rvx_pkg::CLR_AW + 1)'(rvx_pkg::MEM_WORDS);
    assign clr_csr   = {1'b0, clr_reg} < (rvx_pkg::CLR_AW + 1)'(rvx_pkg::CSR_COUNT);

    // decode fields of the latched instruction
    assign op    = insn_reg[6:0];
    assign rd    = insn_reg[11:7];
    assign f3    = insn_reg[14:12];
    assign rs1   = insn_reg[19:15];
    assign f7    = insn_reg[31:25];
    assign imm_i = {{20{insn_reg[31]}}, insn_reg[31:20]};
    assign imm_s = {{20{insn_reg[31]}}, insn_reg[31:25], insn_reg[11:7]};
    assign imm_b = {{20{insn_reg[31]}}, insn_reg[7], insn_reg[30:25], insn_reg[11:8], 1'b0};
    assign imm_j = {{12{insn_reg[31]}}, insn_reg[19:12], insn_reg[20], insn_reg[30:21], 1'b0};
    assign pc4   = pc_reg + 32'd4;
    assign csr_src = f3[2] ? {27'd0, rs1} : a_reg;
    assign ex_off  = ex_addr - base_reg;

    always_comb
    begin
        ex_fault   = rvx_pkg::FLT_NONE;
        ex_wr      = 1'b1;
        ex_r       = '0;
        ex_npc     = pc4;
        ex_kind    = EXK_DONE;
        ex_csr_we  = 1'b0;
        ex_csr_val = csr_reg;
        ex_exit    = 1'b0;
        ex_take    = 1'b0;
        ex_addr    = a_reg + imm_i;
        tgt        = pc_reg + imm_b;
        case (op)
            rvx_pkg::OPC_IMM:
            begin
                case (f3)
                    3'd0: ex_r = a_reg + imm_i;
                    3'd2: ex_r = {31'd0, $signed(a_reg) < $signed(imm_i)};
                    3'd3: ex_r = {31'd0, a_reg < imm_i};
                    3'd4: ex_r = a_reg ^ imm_i;
                    3'd6: ex_r = a_reg | imm_i;
                    3'd7: ex_r = a_reg & imm_i;
                    3'd1:
                    begin
                        if (f7 != rvx_pkg::F7_BASE) ex_fault = rvx_pkg::FLT_ILLEGAL;
                        ex_r = a_reg << insn_reg[24:20];
                    end
                    default:
                    begin
                        if (f7 == rvx_pkg::F7_BASE) ex_r = a_reg >> insn_reg[24:20];
                        else if (f7 == rvx_pkg::F7_ALT)
                            ex_r = 32'($signed(a_reg) >>> insn_reg[24:20]);
                        else ex_fault = rvx_pkg::FLT_ILLEGAL;
                    end
                endcase
            end
            rvx_pkg::OPC_LUI:   ex_r = {insn_reg[31:12], 12'd0};
            rvx_pkg::OPC_AUIPC: ex_r = pc_reg + {insn_reg[31:12], 12'd0};
            rvx_pkg::OPC_REG:
            begin
                if (f7 == rvx_pkg::F7_MULDIV)
                begin
                    ex_kind = EXK_MD;
                end
                else if ((f7 == rvx_pkg::F7_ALT && f3 != 3'd0 && f3 != 3'd5) ||
                         (f7 != rvx_pkg::F7_BASE && f7 != rvx_pkg::F7_ALT))
                begin
                    ex_fault = rvx_pkg::FLT_ILLEGAL;
                end
                else
                begin
                    case (f3)
                        3'd0: ex_r = f7[5] ? a_reg - b_reg : a_reg + b_reg;
                        3'd1: ex_r = a_reg << b_reg[4:0];
                        3'd2: ex_r = {31'd0, $signed(a_reg) < $signed(b_reg)};
                        3'd3: ex_r = {31'd0, a_reg < b_reg};
                        3'd4: ex_r = a_reg ^ b_reg;
                        3'd5: ex_r = f7[5] ? 32'($signed(a_reg) >>> b_reg[4:0])
                                           : a_reg >> b_reg[4:0];
                        3'd6: ex_r = a_reg | b_reg;
                        default: ex_r = a_reg & b_reg;
                    endcase
                end
            end
            rvx_pkg::OPC_JAL:
            begin
                tgt = pc_reg + imm_j;
                if (tgt[1:0] != 2'b00) ex_fault = rvx_pkg::FLT_TARGET;
                ex_r   = pc4;
                ex_npc = tgt;
            end
            rvx_pkg::OPC_JALR:
            begin
                tgt = (a_reg + imm_i) & ~32'd1;
                if (f3 != 3'd0) ex_fault = rvx_pkg::FLT_ILLEGAL;
                else if (tgt[1:0] != 2'b00) ex_fault = rvx_pkg::FLT_TARGET;
                ex_r   = pc4;
                ex_npc = tgt;
            end
            rvx_pkg::OPC_BRANCH:
            begin
                ex_wr = 1'b0;
                case (f3)
                    3'd0: ex_take = (a_reg == b_reg);
                    3'd1: ex_take = (a_reg != b_reg);
                    3'd4: ex_take = $signed(a_reg) < $signed(b_reg);
                    3'd5: ex_take = !($signed(a_reg) < $signed(b_reg));
                    3'd6: ex_take = a_reg < b_reg;
                    3'd7: ex_take = a_reg >= b_reg;
                    default: ex_fault = rvx_pkg::FLT_ILLEGAL;
                endcase
                if (ex_take)
                begin
                    if (tgt[1:0] != 2'b00) ex_fault = rvx_pkg::FLT_TARGET;
                    ex_npc = tgt;
                end
            end
            rvx_pkg::OPC_LOAD:
            begin
                if (f3 == 3'd3 || f3 == 3'd6 || f3 == 3'd7)
                    ex_fault = rvx_pkg::FLT_ILLEGAL;
                else
                    ex_fault = acc_fault(ex_addr, base_reg, 3'd1 << f3[1:0]);
                ex_kind = EXK_LD;
            end
            rvx_pkg::OPC_STORE:
            begin
                ex_addr = a_reg + imm_s;
                ex_wr   = 1'b0;
                if (f3 > 3'd2) ex_fault = rvx_pkg::FLT_ILLEGAL;
                else ex_fault = acc_fault(ex_addr, base_reg, 3'd1 << f3[1:0]);
                ex_kind = EXK_ST;
            end
            rvx_pkg::OPC_FENCE:
            begin
                ex_wr = 1'b0;
                if (f3 != 3'd0) ex_fault = rvx_pkg::FLT_ILLEGAL;
            end
            rvx_pkg::OPC_SYSTEM:
            begin
                if (f3 == 3'd0)
                begin
                    ex_wr = 1'b0;
                    if (rd != 5'd0 || rs1 != 5'd0 || insn_reg[31:20] > 12'd1)
                        ex_fault = rvx_pkg::FLT_ILLEGAL;
                    else if (insn_reg[20])
                        ex_fault = rvx_pkg::FLT_BREAK;
                    else
                        ex_exit = a_reg[0];   // a_reg holds x3 for ECALL
                end
                else if (f3 == 3'd4)
                begin
                    ex_fault = rvx_pkg::FLT_ILLEGAL;
                end
                else
                begin
                    ex_r = csr_reg;
                    if (f3[1:0] == 2'd1)
                    begin
                        ex_csr_we  = 1'b1;
                        ex_csr_val = csr_src;
                    end
                    else if (rs1 != 5'd0)
                    begin
                        ex_csr_we  = 1'b1;
                        ex_csr_val = (f3[1:0] == 2'd2) ? (csr_reg | csr_src)
                                                       : (csr_reg & ~csr_src);
                    end
                end
            end
            default: ex_fault = rvx_pkg::FLT_ILLEGAL;
        endcase
        if (ex_fault != rvx_pkg::FLT_NONE)
        begin
            // drop every side effect
            ex_wr     = 1'b0;
            ex_npc    = pc4;
            ex_kind   = EXK_DONE;
            ex_csr_we = 1'b0;
            ex_exit   = 1'b0;
        end
    end

    // load extraction and store merge on the word read back from memory
    assign ls_sh   = {ls_off_reg, 3'b000};
    assign ld_sw   = mem_rdata >> ls_sh;
    assign st_mask = (f3[1:0] == 2'd0) ? 32'h0000_00FF :
                     (f3[1:0] == 2'd1) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    assign st_word = (mem_rdata & ~(st_mask << ls_sh)) | ((b_reg & st_mask) << ls_sh);

    always_comb
    begin
        case (f3)
            3'd0:    ld_val = {{24{ld_sw[7]}}, ld_sw[7:0]};
            3'd1:    ld_val = {{16{ld_sw[15]}}, ld_sw[15:0]};
            3'd4:    ld_val = {24'd0, ld_sw[7:0]};
            3'd5:    ld_val = {16'd0, ld_sw[15:0]};
            default: ld_val = ld_sw;
        endcase
    end

    // RAM port steering
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = ls_word_reg;
        mem_wdata = st_word;
        rf_we     = wb_go && (res_rd_reg != 5'd0);
        rf_waddr  = res_rd_reg;
        rf_wdata  = res_val_reg;
        csr_we    = wb_go && res_csr_we_reg;
        csr_waddr = insn_reg[31:20];
        csr_wdata = res_csr_val_reg;
        case (state_reg)
            S_CLR:
            begin
                mem_we    = clr_mem;
                mem_waddr = clr_reg[MAW-1:0];
                mem_wdata = '0;
                rf_we     = 1'b1;
                rf_waddr  = clr_reg[4:0];
                rf_wdata  = '0;
                csr_we    = clr_csr;
                csr_waddr = clr_reg[rvx_pkg::CSR_AW-1:0];
                csr_wdata = '0;
            end
            S_IDLE:
            begin
                mem_we    = accept && (kind == rvx_pkg::KIND_LOAD) &&
                            ({18'd0, widx} < 32'(rvx_pkg::MEM_WORDS));
                mem_waddr = MAW'(widx);
                mem_wdata = wdata;
            end
            S_ST:    mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    assign mem_raddr = (state_reg == S_EX) ? ex_off[MAW+1:2] : fetch_off[MAW+1:2];
    assign rf_raddr  = (state_reg == S_DEC) ?
                       ((mem_rdata[6:0] == rvx_pkg::OPC_SYSTEM && mem_rdata[14:12] == 3'd0)
                        ? 5'd3 : mem_rdata[19:15]) : insn_reg[24:20];

    assign md_req.start  = (state_reg == S_EX) && (ex_kind == EXK_MD);
    assign md_req.funct3 = f3;

    rvx_ram #(.DEPTH(rvx_pkg::MEM_WORDS), .WIDTH(32)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    rvx_ram #(.DEPTH(32), .WIDTH(32)) u_regs (
        .clk(clk), .we(rf_we), .waddr(rf_waddr), .wdata(rf_wdata),
        .raddr(rf_raddr), .rdata(rf_rdata)
    );

    rvx_ram #(.DEPTH(rvx_pkg::CSR_COUNT), .WIDTH(32)) u_csr (
        .clk(clk), .we(csr_we), .waddr(csr_waddr), .wdata(csr_wdata),
        .raddr(mem_rdata[31:20]), .rdata(csr_rdata)
    );

    rvx_muldiv u_md (
        .clk(clk), .rst_n(rst_n), .req(md_req), .a(a_reg), .b(b_reg),
        .done(md_done), .result(md_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            pc_reg    <= '0;
            run_reg   <= 1'b0;
            exit_reg  <= '0;
            base_reg  <= '0;
            entry_reg <= '0;
            mv_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == rvx_pkg::CFG_MEM_BASE) base_reg <= cfg_data;
                else if (cfg_index == rvx_pkg::CFG_ENTRY) entry_reg <= cfg_data;
            end
            if (wb_go)
            begin
                mv_reg <= 1'b1;
            end
            else if (mv_reg && m_tready)
            begin
                mv_reg <= 1'b0;
            end
            case (state_reg)
                S_CLR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == rvx_pkg::CLR_AW'(rvx_pkg::CLR_N - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    res_pc_reg     <= pc_reg;
                    res_run_reg    <= run_reg;
                    res_exit_reg   <= exit_reg;
                    res_fault_reg  <= rvx_pkg::FLT_NONE;
                    res_rd_reg     <= '0;
                    res_val_reg    <= '0;
                    res_csr_we_reg <= 1'b0;
                    if (accept)
                    begin
                        state_reg <= S_WB;
                        if (kind == rvx_pkg::KIND_START)
                        begin
                            res_pc_reg  <= entry_reg;
                            res_rd_reg  <= 5'd2;
                            res_val_reg <= base_reg + rvx_pkg::MEM_BYTES - 32'd4;
                            res_run_reg <= 1'b1;
                        end
                        else if (kind == rvx_pkg::KIND_STEP && run_reg)
                        begin
                            if (fetch_flt)
                            begin
                                res_fault_reg <= rvx_pkg::FLT_FETCH;
                                res_run_reg   <= 1'b0;
                            end
                            else
                            begin
                                state_reg <= S_DEC;
                            end
                        end
                    end
                end
                S_DEC:
                begin
                    insn_reg <= mem_rdata;
                    if (mem_rdata == 32'd0)
                    begin
                        res_run_reg <= 1'b0;
                        state_reg   <= S_WB;
                    end
                    else
                    begin
                        state_reg <= S_RA;
                    end
                end
                S_RA:
                begin
                    a_reg     <= rf_rdata;
                    csr_reg   <= csr_rdata;
                    state_reg <= S_RB;
                end
                S_RB:
                begin
                    b_reg     <= rf_rdata;
                    state_reg <= S_EX;
                end
                S_EX:
                begin
                    res_fault_reg   <= ex_fault;
                    res_pc_reg      <= ex_npc;
                    res_csr_we_reg  <= ex_csr_we;
                    res_csr_val_reg <= ex_csr_val;
                    ls_off_reg      <= ex_off[1:0];
                    ls_word_reg     <= ex_off[MAW+1:2];
                    if (ex_exit)
                    begin
                        res_run_reg  <= 1'b0;
                        res_exit_reg <= a_reg[31:1];
                    end
                    case (ex_kind)
                        EXK_MD:  state_reg <= S_MD;
                        EXK_LD:  state_reg <= S_LD;
                        EXK_ST:  state_reg <= S_ST;
                        default:
                        begin
                            res_rd_reg  <= ex_wr ? rd : 5'd0;
                            res_val_reg <= (ex_wr && rd != 5'd0) ? ex_r : 32'd0;
                            state_reg   <= S_WB;
                        end
                    endcase
                end
                S_MD:
                begin
                    if (md_done)
                    begin
                        res_rd_reg  <= rd;
                        res_val_reg <= (rd != 5'd0) ? md_res : 32'd0;
                        state_reg   <= S_WB;
                    end
                end
                S_LD:
                begin
                    res_rd_reg  <= rd;
                    res_val_reg <= (rd != 5'd0) ? ld_val : 32'd0;
                    state_reg   <= S_WB;
                end
                S_ST:
                begin
                    state_reg <= S_WB;
                end
                S_WB:
                begin
                    if (out_free)
                    begin
                        pc_reg    <= res_pc_reg;
                        run_reg   <= res_run_reg;
                        exit_reg  <= res_exit_reg;
                        mdata_reg <= {res_val_reg, res_rd_reg, res_fault_reg,
                                      res_exit_reg, res_run_reg, res_pc_reg};
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/rvx_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module rvx_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/rvx_muldiv.sv]
// Multiply and iterative divide unit for the M extension.
// Depends on rvx_pkg.
module rvx_muldiv (
    input  logic             clk,
    input  logic             rst_n,
    input  rvx_pkg::md_req_t req,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic             done,
    output logic [31:0]      result
);

    typedef enum logic [1:0] {MD_IDLE, MD_MUL, MD_DIV, MD_FIN} md_state_t;

    md_state_t    state_reg;
    logic [2:0]   f3_reg;
    logic [65:0]  prod_reg;
    logic [32:0]  rem_reg;
    logic [31:0]  quo_reg;
    logic [31:0]  dvs_reg;
    logic [31:0]  a_reg;
    logic         zero_reg;
    logic         negq_reg;
    logic         negr_reg;
    logic [4:0]   cnt_reg;
    logic [31:0]  result_reg;

    logic         a_sgn;
    logic         b_sgn;
    logic         div_signed;
    logic [32:0]  rem_sh;
    logic [32:0]  rem_sub;
    logic [31:0]  q_fin;
    logic [31:0]  r_fin;

    assign a_sgn      = (req.funct3 == 3'd1 || req.funct3 == 3'd2) ? a[31] : 1'b0;
    assign b_sgn      = (req.funct3 == 3'd1) ? b[31] : 1'b0;
    assign div_signed = ~req.funct3[0];
    assign rem_sh     = {rem_reg[31:0], quo_reg[31]};
    assign rem_sub    = rem_sh - {1'b0, dvs_reg};
    assign q_fin      = negq_reg ? (32'd0 - quo_reg) : quo_reg;
    assign r_fin      = negr_reg ? (32'd0 - rem_reg[31:0]) : rem_reg[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                MD_IDLE:
                begin
                    if (req.start)
                    begin
                        f3_reg <= req.funct3;
                        if (!req.funct3[2])
                        begin
                            prod_reg  <= 66'($signed({a_sgn, a}) * $signed({b_sgn, b}));
                            state_reg <= MD_MUL;
                        end
                        else
                        begin
                            // work on magnitudes, fix signs at the end
                            rem_reg   <= '0;
                            quo_reg   <= (div_signed && a[31]) ? (32'd0 - a) : a;
                            dvs_reg   <= (div_signed && b[31]) ? (32'd0 - b) : b;
                            a_reg     <= a;
                            zero_reg  <= (b == 32'd0);
                            negq_reg  <= div_signed && (a[31] ^ b[31]);
                            negr_reg  <= div_signed && a[31];
                            cnt_reg   <= '0;
                            state_reg <= MD_DIV;
                        end
                    end
                end
                MD_MUL:
                begin
                    result_reg <= (f3_reg == 3'd0) ? prod_reg[31:0] : prod_reg[63:32];
                    state_reg  <= MD_FIN;
                end
                MD_DIV:
                begin
                    if (!rem_sub[32])
                    begin
                        rem_reg <= rem_sub;
                        quo_reg <= {quo_reg[30:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[30:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= MD_FIN;
                    end
                end
                MD_FIN:
                begin
                    state_reg <= MD_IDLE;
                end
                default:
                begin
                    state_reg <= MD_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        if (f3_reg[2])
        begin
            if (zero_reg)
            begin
                result = f3_reg[1] ? a_reg : 32'hFFFF_FFFF;
            end
            else
            begin
                result = f3_reg[1] ? r_fin : q_fin;
            end
        end
        else
        begin
            result = result_reg;
        end
    end

    assign done = (state_reg == MD_FIN);

endmodule

[hw/rtl/rvx_checker.sv]
// Port-level checker for the RV32IM executor, bound to the top level.
// Depends on rvx_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rvx_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [47:0]  s_tdata,
    input logic [1:0]   s_tuser,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [1:0]   cfg_index,
    input logic [31:0]  cfg_data
);

    logic out_acc;

    assign out_acc = m_tvalid && m_tready;

    // hold a stalled result word
    `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a fetch fault always halts
    `CHK_IMPL(a_fetch_halts, out_acc && m_tdata[66:64] == rvx_pkg::FLT_FETCH, !m_tdata[32])
    // a breakpoint leaves the core running
    `CHK_IMPL(a_break_runs, out_acc && m_tdata[66:64] == rvx_pkg::FLT_BREAK, m_tdata[32])
    // a faulting word writes no register
    `CHK_IMPL(a_fault_no_dest, out_acc && m_tdata[66:64] != rvx_pkg::FLT_NONE,
              m_tdata[71:67] == 5'd0)

endmodule

bind rv32im_instruction_executor rvx_checker u_rvx_checker (.*);
